/* rtl/phd_pkg.sv */
package phd_pkg;

	localparam int MAX_LEVELS_DEF = 24;
	localparam int ALPHABET_SIZE  = 256;
	localparam int LEAF_AW        = $clog2(ALPHABET_SIZE);

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_LEVELS,
		PH_COUNTS,
		PH_VALUES,
		PH_DECODE,
		PH_IDLE
	} phase_t;

	typedef enum logic [2:0] {
		ST_WAIT,
		ST_BINIT,
		ST_BADD,
		ST_BSTEP,
		ST_BFIN,
		ST_BIT,
		ST_READ,
		ST_FLUSH
	} ctrl_state_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_flag;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic build_init;
		logic build_add;
		logic build_step;
		logic build_fin;
		logic bit_step;
		logic read_done;
		logic flush;
	} dp_cmd_t;

	typedef struct packed {
		logic acc_decode;
		logic acc_build;
		logic bi_zero;
		logic pend_v;
		logic out_free;
		logic bit_read;
		logic bit_stop;
		logic bit_last;
		logic bits_done;
	} dp_status_t;

endpackage

/* rtl/phd_ctrl.sv */
module phd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  phd_pkg::dp_status_t st,
	output phd_pkg::dp_cmd_t    cmd
);

	phd_pkg::ctrl_state_t state_q, state_d;
	logic                 bit_go;

	assign bit_go = !st.pend_v || st.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phd_pkg::ST_WAIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			phd_pkg::ST_WAIT: begin
				if (in_valid) begin
					if (st.acc_decode) state_d = phd_pkg::ST_BIT;
					else if (st.acc_build) state_d = phd_pkg::ST_BINIT;
					else state_d = phd_pkg::ST_FLUSH;
				end
			end
			phd_pkg::ST_BINIT: state_d = phd_pkg::ST_BADD;
			phd_pkg::ST_BADD,
			phd_pkg::ST_BSTEP: begin
				state_d = st.bi_zero ? phd_pkg::ST_BFIN : phd_pkg::ST_BSTEP;
			end
			phd_pkg::ST_BFIN: state_d = phd_pkg::ST_FLUSH;
			phd_pkg::ST_BIT: begin
				if (bit_go) begin
					priority if (st.bit_read) state_d = phd_pkg::ST_READ;
					else if (st.bit_stop || st.bit_last) state_d = phd_pkg::ST_FLUSH;
					else state_d = phd_pkg::ST_BIT;
				end
			end
			phd_pkg::ST_READ: state_d = st.bits_done ? phd_pkg::ST_FLUSH : phd_pkg::ST_BIT;
			phd_pkg::ST_FLUSH: begin
				if (!st.pend_v || st.out_free) state_d = phd_pkg::ST_WAIT;
			end
			default: state_d = phd_pkg::ST_WAIT;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			phd_pkg::ST_WAIT: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			phd_pkg::ST_BINIT: cmd.build_init = 1'b1;
			phd_pkg::ST_BADD:  cmd.build_add  = 1'b1;
			phd_pkg::ST_BSTEP: cmd.build_step = 1'b1;
			phd_pkg::ST_BFIN:  cmd.build_fin  = 1'b1;
			phd_pkg::ST_BIT:   cmd.bit_step   = bit_go;
			phd_pkg::ST_READ:  cmd.read_done  = 1'b1;
			phd_pkg::ST_FLUSH: cmd.flush      = st.pend_v && st.out_free;
			default: ;
		endcase
	end

endmodule

/* rtl/phd_dp.sv */
module phd_dp #(
	parameter int MAX_LEVELS = phd_pkg::MAX_LEVELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  phd_pkg::in_item_t    in_data,
	output phd_pkg::out_item_t   out_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  phd_pkg::dp_cmd_t     cmd,
	output phd_pkg::dp_status_t  st
);

	localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

	phd_pkg::phase_t phase_q, phase_e;
	logic [31:0] bytes_left_q, bl_e;
	logic [4:0]  level_total_q;
	logic [8:0]  leaves_q [MAX_LEVELS];
	logic [7:0]  inner_q  [MAX_LEVELS];
	logic [8:0]  first_q  [MAX_LEVELS];
	logic [7:0]  leaf_mem [phd_pkg::ALPHABET_SIZE];
	logic [8:0]  end_marker_q;
	logic [25:0] open_q;
	logic [8:0]  leaf_sum_q;
	logic [8:0]  tc_q, tc_e, tc_n;
	logic [8:0]  cv_q;
	logic [4:0]  cl_q;
	logic [9:0]  node_q;
	logic [LVL_W-1:0] bi_q;
	logic [7:0]  sh_q;
	logic [3:0]  bitcnt_q;
	logic [7:0]  rd_q;
	phd_pkg::out_item_t pend_q, out_q;
	logic        pend_v_q, out_v_q;

	logic [7:0]  b;
	logic [25:0] b26, open_n;
	logic [8:0]  ls_n;
	logic        cnt_err, values_done;
	logic [LVL_W-1:0] lvl_cnt, lvl_last, lvl_cl;
	logic [8:0]  leaf_bi, leaf_add;
	logic [9:0]  node_sh;
	logic [8:0]  cv_n, inner9, idx;
	logic        go_deeper, is_end, bit_read, has_result;
	logic        out_free;

	assign b       = in_data.in_byte;
	assign phase_e = in_data.start_flag ? phd_pkg::PH_SIZE : phase_q;
	assign bl_e    = in_data.start_flag ? 32'd0 : bytes_left_q;
	assign tc_e    = in_data.start_flag ? 9'd0 : tc_q;
	assign tc_n    = tc_e + 9'd1;

	assign b26     = {18'd0, b};
	assign ls_n    = leaf_sum_q + {1'b0, b};
	assign cnt_err = (ls_n > 9'd255) || (b26 > open_q)
		|| ((b26 >= open_q) && (tc_n == {4'd0, level_total_q}));
	assign open_n  = ((open_q - b26 + 26'd1) << 1) - 26'd1;
	assign values_done = tc_n > leaf_sum_q;

	assign lvl_cnt  = tc_e[LVL_W-1:0];
	assign lvl_last = LVL_W'(level_total_q - 5'd1);
	assign lvl_cl   = cl_q[LVL_W-1:0];
	assign leaf_bi  = leaves_q[bi_q];
	assign leaf_add = leaf_bi + 9'd2;
	assign node_sh  = node_q >> 1;

	assign cv_n      = {cv_q[7:0], sh_q[7]};
	assign inner9    = {1'b0, inner_q[lvl_cl]};
	assign go_deeper = (cv_n < inner9) && ((cl_q + 5'd1) < level_total_q);
	assign idx       = cv_n - inner9 + first_q[lvl_cl];
	assign is_end    = idx == end_marker_q;
	assign bit_read  = !go_deeper && !is_end && (bytes_left_q != 32'd0);
	assign has_result = !go_deeper;

	assign out_free  = !out_v_q || out_ready;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_comb begin
		st.acc_decode = phase_e == phd_pkg::PH_DECODE;
		st.acc_build  = (phase_e == phd_pkg::PH_VALUES) && values_done;
		st.bi_zero    = bi_q == '0;
		st.pend_v     = pend_v_q;
		st.out_free   = out_free;
		st.bit_read   = bit_read;
		st.bit_stop   = has_result && !bit_read;
		st.bit_last   = bitcnt_q == 4'd1;
		st.bits_done  = bitcnt_q == 4'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && phase_e == phd_pkg::PH_COUNTS) begin
			first_q[lvl_cnt]  <= leaf_sum_q;
			leaves_q[lvl_cnt] <= {1'b0, b};
		end
		if (cmd.accept && phase_e == phd_pkg::PH_VALUES) begin
			leaf_mem[tc_e[phd_pkg::LEAF_AW-1:0]] <= b;
		end
		if (cmd.build_init) begin
			inner_q[lvl_last] <= 8'd0;
		end
		if (cmd.build_add) begin
			leaves_q[bi_q] <= leaf_add;
		end
		if (cmd.build_step) begin
			inner_q[bi_q] <= node_sh[7:0];
		end
		if (cmd.bit_step) begin
			rd_q <= leaf_mem[idx[phd_pkg::LEAF_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= phd_pkg::PH_SIZE;
			bytes_left_q  <= '0;
			level_total_q <= '0;
			end_marker_q  <= '0;
			open_q        <= 26'd1;
			leaf_sum_q    <= '0;
			tc_q          <= '0;
			cv_q          <= '0;
			cl_q          <= '0;
			node_q        <= '0;
			bi_q          <= '0;
			sh_q          <= '0;
			bitcnt_q      <= '0;
			pend_q        <= '0;
			pend_v_q      <= 1'b0;
			out_q         <= '0;
			out_v_q       <= 1'b0;
		end else begin
			if (out_ready) out_v_q <= 1'b0;

			if (cmd.accept) begin
				phase_q      <= phase_e;
				bytes_left_q <= bl_e;
				tc_q         <= tc_e;
				unique case (phase_e)
					phd_pkg::PH_SIZE: begin
						bytes_left_q <= {bl_e[23:0], b};
						if (tc_n >= 9'd4) begin
							tc_q    <= '0;
							phase_q <= phd_pkg::PH_LEVELS;
						end else begin
							tc_q <= tc_n;
						end
					end
					phd_pkg::PH_LEVELS: begin
						if (b == 8'd0 || b > 8'(MAX_LEVELS)) begin
							pend_q   <= '{out_byte: 8'd0, kind: phd_pkg::KIND_ERROR,
								last_of_run: 1'b0};
							pend_v_q <= 1'b1;
							phase_q  <= phd_pkg::PH_IDLE;
						end else begin
							level_total_q <= b[4:0];
							tc_q          <= '0;
							leaf_sum_q    <= '0;
							open_q        <= 26'd1;
							phase_q       <= phd_pkg::PH_COUNTS;
						end
					end
					phd_pkg::PH_COUNTS: begin
						leaf_sum_q <= ls_n;
						tc_q       <= tc_n;
						if (cnt_err) begin
							pend_q   <= '{out_byte: 8'd0, kind: phd_pkg::KIND_ERROR,
								last_of_run: 1'b0};
							pend_v_q <= 1'b1;
							phase_q  <= phd_pkg::PH_IDLE;
						end else begin
							open_q <= open_n;
							if (tc_n >= {4'd0, level_total_q}) begin
								tc_q    <= '0;
								phase_q <= phd_pkg::PH_VALUES;
							end
						end
					end
					phd_pkg::PH_VALUES: begin
						tc_q <= tc_n;
						if (values_done) begin
							end_marker_q <= leaf_sum_q + 9'd1;
							tc_q         <= '0;
						end
					end
					phd_pkg::PH_DECODE: begin
						sh_q     <= b;
						bitcnt_q <= 4'd8;
					end
					default: ;
				endcase
			end

			if (cmd.build_init) begin
				bi_q <= lvl_last;
			end
			if (cmd.build_add) begin
				node_q <= {1'b0, leaf_add};
				if (bi_q != '0) bi_q <= bi_q - LVL_W'(1);
			end
			if (cmd.build_step) begin
				node_q <= node_sh + {1'b0, leaf_bi};
				if (bi_q != '0) bi_q <= bi_q - LVL_W'(1);
			end
			if (cmd.build_fin) begin
				if (node_sh == 10'd1) begin
					cv_q    <= '0;
					cl_q    <= '0;
					phase_q <= phd_pkg::PH_DECODE;
				end else begin
					pend_q   <= '{out_byte: 8'd0, kind: phd_pkg::KIND_ERROR,
						last_of_run: 1'b0};
					pend_v_q <= 1'b1;
					phase_q  <= phd_pkg::PH_IDLE;
				end
			end

			if (cmd.bit_step) begin
				sh_q     <= {sh_q[6:0], 1'b0};
				bitcnt_q <= bitcnt_q - 4'd1;
				if (go_deeper) begin
					cv_q <= cv_n;
					cl_q <= cl_q + 5'd1;
				end else begin
					cv_q <= '0;
					cl_q <= '0;
					if (pend_v_q) begin
						out_q   <= '{out_byte: pend_q.out_byte, kind: pend_q.kind,
							last_of_run: 1'b0};
						out_v_q <= 1'b1;
					end
					if (bit_read) begin
						bytes_left_q <= bytes_left_q - 32'd1;
						pend_v_q     <= 1'b0;
					end else begin
						pend_q   <= '{out_byte: 8'd0,
							kind: (is_end && bytes_left_q == 32'd0) ?
								phd_pkg::KIND_END : phd_pkg::KIND_ERROR,
							last_of_run: 1'b0};
						pend_v_q <= 1'b1;
						phase_q  <= phd_pkg::PH_IDLE;
					end
				end
			end

			if (cmd.read_done) begin
				pend_q   <= '{out_byte: rd_q, kind: phd_pkg::KIND_BYTE, last_of_run: 1'b0};
				pend_v_q <= 1'b1;
			end

			if (cmd.flush) begin
				out_q    <= '{out_byte: pend_q.out_byte, kind: pend_q.kind,
					last_of_run: 1'b1};
				out_v_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/pack_huffman_stream_decoder.sv */
// Decoder for the old pack compressed format (canonical Huffman with an
// end-of-stream code). Input beats carry one stream byte each, starting with
// the 32-bit big-endian output size; start_flag on a beat restarts parsing.
// Output beats carry a decoded byte, an end mark or an error mark; the last
// result caused by an input beat has last_of_run set.
// Header and table bytes are each accepted and then pass a flush step. The byte
// that completes the leaf values also runs the tree build, one level per cycle.
// A code byte is walked one bit per cycle while the output can take results,
// with a leaf memory read step for each decoded byte, after the accept step
// and before a flush step that hands over the final result; an end or error
// code stops the walk early.
// One result waits in a holding stage and one in the output register, so the
// next input beat is taken while the last result is still unclaimed. When the
// receiver stalls, decoding halts at the next result until the output
// register frees up.
// Reset leaves the block waiting for size bytes with no results pending; the
// level and leaf tables are not cleared and need no clearing time.
module pack_huffman_stream_decoder #(
	parameter int MAX_LEVELS = phd_pkg::MAX_LEVELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  phd_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output phd_pkg::out_item_t out_data
);

	phd_pkg::dp_cmd_t    cmd;
	phd_pkg::dp_status_t st;

	phd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	phd_dp #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
